FILE: hw/rtl/clh_pkg.sv
package clh_pkg;

    localparam int LIST_DEPTH = 16;
    localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
    localparam int HANDLE_W   = 32;
    localparam int CMD_W      = 3;
    localparam int STATUS_W   = 2;
    localparam int ENT_W      = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_READ   = 3'd0,
        CMD_NEXT   = 3'd1,
        CMD_PREV   = 3'd2,
        CMD_ADD    = 3'd3,
        CMD_REMOVE = 3'd4
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE     = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    // Per-cycle control broadcast to every cell
    typedef struct packed {
        logic load_match;
        logic shift_add;
        logic shift_rem;
    } t_cell_ctl;

endpackage

FILE: hw/rtl/clh_cell.sv
module clh_cell (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  clh_pkg::t_cell_ctl             i_ctl,
    input  logic                           i_live,
    input  logic [clh_pkg::HANDLE_W-1:0]   i_handle,
    input  logic [clh_pkg::HANDLE_W-1:0]   i_prev_data,
    input  logic [clh_pkg::HANDLE_W-1:0]   i_next_data,
    input  logic                           i_prior,
    output logic                           o_prior,
    output logic                           o_first,
    output logic [clh_pkg::HANDLE_W-1:0]   o_data,
    output logic [clh_pkg::HANDLE_W-1:0]   o_n_data
);

    logic [clh_pkg::HANDLE_W-1:0] r_data;
    logic [clh_pkg::HANDLE_W-1:0] n_data;
    logic                         r_match;

    // Match chain: a match at or in front of this cell ripples toward the back
    assign o_prior = i_prior | r_match;
    assign o_first = r_match & ~i_prior;

    always_comb begin
        n_data = r_data;
        if (i_ctl.shift_add) begin
            n_data = i_prev_data;
        end else if (i_ctl.shift_rem && o_prior) begin
            // close the gap: take the neighbour behind
            n_data = i_next_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b0;
        end else if (i_ctl.load_match) begin
            r_match <= i_live && (r_data == i_handle);
        end
    end

    assign o_data   = r_data;
    assign o_n_data = n_data;

endmodule

FILE: hw/rtl/cursor_list_of_handles.sv
// Cursor list of handles: an ordered list of up to clh_pkg::LIST_DEPTH 32-bit
// handles, front at position 0, with a cursor that may point at one entry.
// Input channel (i_in_valid / o_in_ready) carries one command item: i_cmd and
// i_handle. Output channel (o_out_valid / i_out_ready) returns exactly one
// result item per command: o_item (handle under the cursor, zero if none),
// o_status and o_entries_now.
// The list lives in a chain of identical cells, one handle each. At the
// accept edge every cell registers whether it holds the requested handle;
// in the apply state a prefix chain through the cells picks the first match.
// When the command commits, every cell loads from its front neighbour for
// add, and for remove every cell at or behind the match loads from its back
// neighbour. The result item is registered when the command commits; the
// block accepts no new command until it has left the apply state.
// A finished result waits in the output register; the block still accepts
// the next command, and holds that command in the apply cycle until the
// receiver takes the earlier result.
// Reset empties the list and invalidates the cursor; handle contents are not
// cleared, and only entries below the count are ever read.
module cursor_list_of_handles (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [clh_pkg::CMD_W-1:0]      i_cmd,
    input  logic [clh_pkg::HANDLE_W-1:0]   i_handle,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [clh_pkg::HANDLE_W-1:0]   o_item,
    output logic [clh_pkg::STATUS_W-1:0]   o_status,
    output logic [clh_pkg::ENT_W-1:0]      o_entries_now
);

    localparam int DEPTH = clh_pkg::LIST_DEPTH;

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_APPLY = 2'b10
    } t_state;

    t_state                        r_state, n_state;
    clh_pkg::t_cmd                 r_cmd;
    logic [clh_pkg::HANDLE_W-1:0]  r_handle;
    logic [clh_pkg::CNT_W-1:0]     r_count, n_count;
    logic [clh_pkg::IDX_W-1:0]     r_cur, n_cur;
    logic                          r_cur_valid, n_cur_valid;

    logic                          r_out_valid;
    logic [clh_pkg::HANDLE_W-1:0]  r_item;
    clh_pkg::t_status              r_status, n_status;
    logic [clh_pkg::ENT_W-1:0]     r_entries;

    clh_pkg::t_cell_ctl            w_ctl;
    logic                          w_accept;
    logic                          w_fire;
    logic                          w_empty;
    logic                          w_full;
    logic                          w_found;
    logic [clh_pkg::CNT_W-1:0]     w_cur_ext;

    logic [clh_pkg::HANDLE_W-1:0]  w_data   [DEPTH];
    logic [clh_pkg::HANDLE_W-1:0]  w_n_data [DEPTH];
    logic [DEPTH:0]                w_prior;
    logic [DEPTH-1:0]              w_first;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    // commit only when the output register is free or being emptied
    assign w_fire     = (r_state == S_APPLY) && (!r_out_valid || i_out_ready);

    assign w_empty   = (r_count == '0);
    assign w_full    = (r_count == clh_pkg::CNT_W'(DEPTH));
    assign w_found   = w_prior[DEPTH];
    assign w_cur_ext = clh_pkg::CNT_W'(r_cur);

    assign w_prior[0] = 1'b0;

    // Row of cells; front neighbour of cell 0 is the incoming handle
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        logic [clh_pkg::HANDLE_W-1:0] w_prev;
        logic [clh_pkg::HANDLE_W-1:0] w_next;
        logic                         w_live;

        if (k == 0) begin : g_front
            assign w_prev = r_handle;
        end else begin : g_mid
            assign w_prev = w_data[k-1];
        end

        if (k == DEPTH - 1) begin : g_back
            assign w_next = w_data[k];
        end else begin : g_inner
            assign w_next = w_data[k+1];
        end

        assign w_live = (r_count > clh_pkg::CNT_W'(k));

        clh_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_live      (w_live),
            .i_handle    (i_handle),
            .i_prev_data (w_prev),
            .i_next_data (w_next),
            .i_prior     (w_prior[k]),
            .o_prior     (w_prior[k+1]),
            .o_first     (w_first[k]),
            .o_data      (w_data[k]),
            .o_n_data    (w_n_data[k])
        );
    end

    // Command decode and cursor repair for the apply cycle
    always_comb begin
        w_ctl            = '0;
        w_ctl.load_match = w_accept;
        n_state          = r_state;
        n_count          = r_count;
        n_cur            = r_cur;
        n_cur_valid      = r_cur_valid;
        n_status         = clh_pkg::ST_DONE;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                case (r_cmd)
                    clh_pkg::CMD_NEXT: begin
                        if (!r_cur_valid || (w_cur_ext + 1'b1 >= r_count)) begin
                            // wrap to the front
                            n_cur_valid = !w_empty;
                            n_cur       = '0;
                        end else begin
                            n_cur = r_cur + 1'b1;
                        end
                        if (w_empty) begin
                            n_status = clh_pkg::ST_EMPTY;
                        end
                    end
                    clh_pkg::CMD_PREV: begin
                        if (!r_cur_valid || (r_cur == '0)) begin
                            n_cur_valid = !w_empty;
                            n_cur       = '0;
                        end else begin
                            n_cur = r_cur - 1'b1;
                        end
                        if (w_empty) begin
                            n_status = clh_pkg::ST_EMPTY;
                        end
                    end
                    clh_pkg::CMD_ADD: begin
                        if (w_full) begin
                            n_status = clh_pkg::ST_FULL;
                        end else begin
                            w_ctl.shift_add = w_fire;
                            n_count         = r_count + 1'b1;
                            // cursor follows its entry one place back
                            if (r_cur_valid) begin
                                n_cur = r_cur + 1'b1;
                            end
                        end
                    end
                    clh_pkg::CMD_REMOVE: begin
                        if (!w_found) begin
                            n_status = clh_pkg::ST_NOTFOUND;
                        end else begin
                            w_ctl.shift_rem = w_fire;
                            n_count         = r_count - 1'b1;
                            if (r_cur_valid) begin
                                if (w_first[r_cur]) begin
                                    // own entry gone: drop the cursor
                                    n_cur_valid = 1'b0;
                                    n_cur       = '0;
                                end else if (w_prior[r_cur]) begin
                                    n_cur = r_cur - 1'b1;
                                end
                            end
                        end
                    end
                    default: begin
                        if (w_empty) begin
                            n_status = clh_pkg::ST_EMPTY;
                        end
                    end
                endcase

                if (!w_fire) begin
                    // hold everything until the result can be taken
                    n_count     = r_count;
                    n_cur       = r_cur;
                    n_cur_valid = r_cur_valid;
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_cur       <= '0;
            r_cur_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_cur       <= n_cur;
            r_cur_valid <= n_cur_valid;
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Command and result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd    <= clh_pkg::t_cmd'(i_cmd);
            r_handle <= i_handle;
        end
        if (w_fire) begin
            r_item    <= n_cur_valid ? w_n_data[n_cur] : '0;
            r_status  <= n_status;
            r_entries <= clh_pkg::ENT_W'(n_count);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_item        = r_item;
    assign o_status      = r_status;
    assign o_entries_now = r_entries;

    a_cursor_in_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_valid |-> (w_cur_ext < r_count))
        else $error("cursor points beyond the last entry");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= clh_pkg::CNT_W'(DEPTH))
        else $error("entry count above list depth");

    a_result_after_apply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept |=> (r_state == S_APPLY)))
        else $error("accepted command did not reach the apply cycle");

    a_full_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && (n_status == clh_pkg::ST_FULL)) |-> (n_count == r_count))
        else $error("add to a full list changed the count");

endmodule
